/* design/tle_pkg.sv */
// package with types and constants for the terminal line editor
package tle_pkg;
   localparam int LINE_BYTES_DEF    = 32;
   localparam int HISTORY_LINES_DEF = 8;

   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_LBR   = 8'h5b;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_K     = 8'h4b;
   localparam logic [7:0] CH_UP    = 8'h41;
   localparam logic [7:0] CH_DOWN  = 8'h42;
   localparam logic [7:0] CH_RIGHT = 8'h43;
   localparam logic [7:0] CH_LEFT  = 8'h44;

   localparam logic KIND_START = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIXED,
      ST_READ,
      ST_EMIT_DATA,
      ST_CMD_READ,
      ST_CMD_EMIT
   } state_type;

   // fixed byte sequences: index is a phrase code
   typedef enum logic [2:0] {
      PH_PROMPT,
      PH_CRLF,
      PH_BACKSPACE,
      PH_CLEAR,
      PH_RIGHT,
      PH_LEFT,
      PH_PAIR
   } phrase_type;

   function automatic logic [3:0] phrase_len(phrase_type p);
      case (p)
         PH_PROMPT:    phrase_len = 4'd3;
         PH_CRLF:      phrase_len = 4'd2;
         PH_BACKSPACE: phrase_len = 4'd3;
         PH_CLEAR:     phrase_len = 4'd8;
         PH_RIGHT:     phrase_len = 4'd3;
         PH_LEFT:      phrase_len = 4'd3;
         PH_PAIR:      phrase_len = 4'd2;
         default:      phrase_len = 4'd0;
      endcase
   endfunction

   function automatic logic [7:0] phrase_byte(phrase_type p, logic [3:0] i,
                                              logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = CH_SP;
      case (p)
         PH_PROMPT:    r = (i == 4'd0) ? CH_DASH : (i == 4'd1) ? CH_GT : CH_SP;
         PH_CRLF:      r = (i == 4'd0) ? CH_CR : CH_LF;
         PH_BACKSPACE: r = (i == 4'd1) ? CH_SP : CH_BS;
         PH_CLEAR: begin
            case (i)
               4'd0:    r = CH_ESC;
               4'd1:    r = CH_LBR;
               4'd2:    r = CH_TWO;
               4'd3:    r = CH_K;
               4'd4:    r = CH_CR;
               4'd5:    r = CH_DASH;
               4'd6:    r = CH_GT;
               default: r = CH_SP;
            endcase
         end
         PH_RIGHT:     r = (i == 4'd0) ? CH_ESC : (i == 4'd1) ? CH_LBR : CH_RIGHT;
         PH_LEFT:      r = (i == 4'd0) ? CH_ESC : (i == 4'd1) ? CH_LBR : CH_LEFT;
         PH_PAIR:      r = (i == 4'd0) ? a : b;
         default:      r = CH_SP;
      endcase
      return r;
   endfunction
endpackage

/* design/tle_ram.sv */
// generic single-port-write ram with registered read
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* design/terminal_line_editor_with_history.sv */
// top level of the terminal line editor with history
// A request transaction is accepted in idle, then its fixed phrase bytes are
// emitted one per cycle while the output slot is free, each line byte takes a
// line-store read and then the emit, and one more step closes each phrase list.
// A line-store read starts only after the previous line byte is loaded into
// the output register, because the ram read is registered, so line byte reads
// do not overlap. Line bytes live in a ram of HISTORY_LINES*LINE_BYTES bytes,
// lengths in flip-flops, so no clearing pass is needed after reset.
module terminal_line_editor_with_history #(
   parameter int LINE_BYTES    = tle_pkg::LINE_BYTES_DEF,
   parameter int HISTORY_LINES = tle_pkg::HISTORY_LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic [1:0]  rsp_tuser,   // command_end, dest
   output logic        rsp_tlast    // last
);
   import tle_pkg::*;

   localparam int LW = $clog2(HISTORY_LINES);
   localparam int NW = $clog2(LINE_BYTES + 1);
   localparam int AW = $clog2(HISTORY_LINES * LINE_BYTES);
   localparam logic [LW-1:0] LAST_LINE = LW'(HISTORY_LINES - 1);
   localparam logic [NW-1:0] MAX_LEN = NW'(LINE_BYTES - 1);

   state_type state_ff, state_in;

   logic [NW-1:0] len_ff [HISTORY_LINES];
   logic [NW-1:0] len_in [HISTORY_LINES];
   logic [HISTORY_LINES-1:0] used_ff, used_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [NW-1:0] cursor_ff, cursor_in;
   logic [1:0]    esc_ff, esc_in;
   logic [7:0]    esc_first_ff, esc_first_in;
   logic          open_ff, open_in;

   // phrase queue: up to three phrases then optional data tail
   phrase_type ph_ff [3];
   phrase_type ph_in [3];
   logic [1:0] ph_cnt_ff, ph_cnt_in;
   logic [1:0] ph_idx_ff, ph_idx_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] pa_ff, pa_in, pb_ff, pb_in;
   logic       tail_ff, tail_in;       // redraw data after phrases
   logic       cmd_ff, cmd_in;         // command dump after first phrase
   logic       begin_ff, begin_in;     // line begin after command or empty line
   logic [NW-1:0] di_ff, di_in;
   logic [NW-1:0] dlen_ff, dlen_in;

   logic          out_v_ff, out_v_in;
   logic [7:0]    out_b_ff, out_b_in;
   logic          out_d_ff, out_d_in;
   logic          out_e_ff, out_e_in;
   logic          out_l_ff, out_l_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   tle_ram #(.WIDTH(8), .DEPTH(HISTORY_LINES * LINE_BYTES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic logic [LW-1:0] rnext(logic [LW-1:0] i);
      return (i == LAST_LINE) ? '0 : LW'(i + 1'b1);
   endfunction
   function automatic logic [LW-1:0] rprev(logic [LW-1:0] i);
      return (i == '0) ? LAST_LINE : LW'(i - 1'b1);
   endfunction

   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_b_ff;
   assign rsp_tuser  = {out_e_ff, out_d_ff};
   assign rsp_tlast  = out_l_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         used_ff   <= '0;
         cur_ff    <= '0;
         cursor_ff <= '0;
         esc_ff    <= '0;
         esc_first_ff <= '0;
         open_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         for (int i = 0; i < HISTORY_LINES; i++) len_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         cur_ff    <= cur_in;
         cursor_ff <= cursor_in;
         esc_ff    <= esc_in;
         esc_first_ff <= esc_first_in;
         open_ff   <= open_in;
         out_v_ff  <= out_v_in;
         for (int i = 0; i < HISTORY_LINES; i++) len_ff[i] <= len_in[i];
      end
      ph_ff     <= ph_in;
      ph_cnt_ff <= ph_cnt_in;
      ph_idx_ff <= ph_idx_in;
      pos_ff    <= pos_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      tail_ff   <= tail_in;
      cmd_ff    <= cmd_in;
      begin_ff  <= begin_in;
      di_ff     <= di_in;
      dlen_ff   <= dlen_in;
      out_b_ff  <= out_b_in;
      out_d_ff  <= out_d_in;
      out_e_ff  <= out_e_in;
      out_l_ff  <= out_l_in;
   end

   always_comb begin
      logic [NW-1:0] len;
      logic [LW-1:0] tgt;
      logic          slot_free;
      logic          more;
      state_in  = state_ff;
      len_in    = len_ff;
      used_in   = used_ff;
      cur_in    = cur_ff;
      cursor_in = cursor_ff;
      esc_in    = esc_ff;
      esc_first_in = esc_first_ff;
      open_in   = open_ff;
      ph_in     = ph_ff;
      ph_cnt_in = ph_cnt_ff;
      ph_idx_in = ph_idx_ff;
      pos_in    = pos_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      tail_in   = tail_ff;
      cmd_in    = cmd_ff;
      begin_in  = begin_ff;
      di_in     = di_ff;
      dlen_in   = dlen_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      out_b_in  = out_b_ff;
      out_d_in  = out_d_ff;
      out_e_in  = out_e_ff;
      out_l_in  = out_l_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(cur_ff * LINE_BYTES + cursor_ff);
      wr_data   = req_tdata;
      rd_addr   = AW'(cur_ff * LINE_BYTES + di_ff);
      len       = len_ff[cur_ff];
      tgt       = '0;
      slot_free = !out_v_ff || rsp_tready;
      more      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               ph_cnt_in = '0;
               ph_idx_in = '0;
               pos_in    = '0;
               tail_in   = 1'b0;
               cmd_in    = 1'b0;
               begin_in  = 1'b0;
               di_in     = '0;
               pa_in     = esc_first_ff;
               pb_in     = req_tdata;
               if (req_tuser == KIND_START) begin
                  open_in = 1'b1;
                  esc_in  = '0;
                  ph_in[0] = PH_PROMPT;
                  ph_cnt_in = 2'd1;
                  len_in[cur_ff] = '0;
                  used_in[cur_ff] = 1'b1;
                  cursor_in = '0;
                  used_in[rnext(cur_ff)] = 1'b0;
                  len_in[rnext(cur_ff)] = '0;
               end else if (open_ff) begin
                  if (esc_ff == 2'd1) begin
                     esc_first_in = req_tdata;
                     esc_in = 2'd2;
                  end else if (esc_ff == 2'd2) begin
                     esc_in = '0;
                     if (esc_first_ff != CH_LBR) begin
                        ph_in[0] = PH_PAIR;
                        ph_cnt_in = 2'd1;
                     end else begin
                        case (req_tdata)
                           CH_UP, CH_DOWN: begin
                              tgt = (req_tdata == CH_UP) ? rprev(cur_ff) : rnext(cur_ff);
                              if (used_ff[tgt]) begin
                                 cur_in = tgt;
                                 cursor_in = len_ff[tgt];
                                 ph_in[0] = PH_CLEAR;
                                 ph_cnt_in = 2'd1;
                                 dlen_in = len_ff[tgt];
                                 tail_in = (len_ff[tgt] != '0);
                              end
                           end
                           CH_RIGHT: begin
                              if (cursor_ff != len) begin
                                 cursor_in = NW'(cursor_ff + 1'b1);
                                 ph_in[0] = PH_RIGHT;
                                 ph_cnt_in = 2'd1;
                              end
                           end
                           CH_LEFT: begin
                              if (cursor_ff != '0) begin
                                 cursor_in = NW'(cursor_ff - 1'b1);
                                 ph_in[0] = PH_LEFT;
                                 ph_cnt_in = 2'd1;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end else if (req_tdata == CH_CR) begin
                     ph_in[0] = PH_CRLF;
                     ph_cnt_in = 2'd1;
                     if (len == '0) begin
                        used_in[cur_ff] = 1'b0;
                        begin_in = 1'b1;
                     end else begin
                        cmd_in  = 1'b1;
                        dlen_in = len;
                     end
                  end else if (req_tdata == CH_BS) begin
                     if (cursor_ff == len && cursor_ff != '0) begin
                        ph_in[0] = PH_BACKSPACE;
                        ph_cnt_in = 2'd1;
                        cursor_in = NW'(cursor_ff - 1'b1);
                        len_in[cur_ff] = NW'(len - 1'b1);
                     end
                  end else if (req_tdata == CH_ESC) begin
                     esc_in = 2'd1;
                  end else if (len < MAX_LEN && cursor_ff < MAX_LEN) begin
                     ph_in[0] = PH_PAIR;
                     pa_in = req_tdata;
                     ph_cnt_in = 2'd1;
                     wr_en = 1'b1;
                     // pair phrase of one byte: use pos 1 so only b is sent
                     pos_in = 4'd1;
                     cursor_in = NW'(cursor_ff + 1'b1);
                     if (NW'(cursor_ff + 1'b1) > len) len_in[cur_ff] = NW'(cursor_ff + 1'b1);
                  end
               end
               state_in = ST_FIXED;
            end
         end
         ST_FIXED: begin
            if (ph_idx_ff >= ph_cnt_ff) begin
               // nothing left in the phrase list
               if (cmd_ff) begin
                  state_in = ST_CMD_READ;
               end else if (tail_ff) begin
                  state_in = ST_READ;
               end else if (begin_ff) begin
                  begin_in = 1'b0;
                  ph_in[0] = PH_PROMPT;
                  ph_cnt_in = 2'd1;
                  ph_idx_in = '0;
                  pos_in = '0;
                  len_in[cur_ff] = '0;
                  used_in[cur_ff] = 1'b1;
                  cursor_in = '0;
                  used_in[rnext(cur_ff)] = 1'b0;
                  len_in[rnext(cur_ff)] = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (slot_free) begin
               more = (pos_ff + 1'b1 < phrase_len(ph_ff[ph_idx_ff]))
                   || (ph_idx_ff + 1'b1 < ph_cnt_ff) || tail_ff || cmd_ff || begin_ff;
               out_v_in = 1'b1;
               out_b_in = phrase_byte(ph_ff[ph_idx_ff], pos_ff, pa_ff, pb_ff);
               out_d_in = 1'b0;
               out_e_in = 1'b0;
               out_l_in = !more;
               if (pos_ff + 1'b1 < phrase_len(ph_ff[ph_idx_ff])) begin
                  pos_in = pos_ff + 1'b1;
               end else begin
                  pos_in = '0;
                  ph_idx_in = ph_idx_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT_DATA;
         end
         ST_EMIT_DATA: begin
            if (slot_free) begin
               out_v_in = 1'b1;
               out_b_in = rd_data;
               out_d_in = 1'b0;
               out_e_in = 1'b0;
               out_l_in = (NW'(di_ff + 1'b1) == dlen_ff);
               di_in = NW'(di_ff + 1'b1);
               if (NW'(di_ff + 1'b1) == dlen_ff) begin
                  tail_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_CMD_READ: begin
            state_in = ST_CMD_EMIT;
         end
         ST_CMD_EMIT: begin
            if (slot_free) begin
               out_v_in = 1'b1;
               out_b_in = rd_data;
               out_d_in = 1'b1;
               out_e_in = (NW'(di_ff + 1'b1) == dlen_ff);
               out_l_in = 1'b0;
               di_in = NW'(di_ff + 1'b1);
               if (NW'(di_ff + 1'b1) == dlen_ff) begin
                  cmd_in = 1'b0;
                  begin_in = 1'b1;
                  cur_in = rnext(cur_ff);
                  state_in = ST_FIXED;
               end else begin
                  state_in = ST_CMD_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* design/tle_checker.sv */
// port-level assertions for the terminal line editor, bound to the top level
module tle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(req_tvalid && req_tready))
      else $error("request taken while a response waits");

   a_end_is_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && !rsp_tlast)
      else $error("command end outside a command line");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("response after the last of a transaction");
endmodule

bind terminal_line_editor_with_history tle_checker u_tle_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
